[design/bbfs_pkg.sv]
// Shared constants, types and microcode table for the bounded BFS candidate selector.
// Used by bounded_bfs_candidate_select_unit; no dependencies.
package bbfs_pkg;

  localparam int MAX_NODES   = 64;
  localparam int NODE_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = NODE_W + 1;
  localparam int ROW_W       = 64;
  localparam int CFG_W       = 7;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 8;

  // tdata field offsets of an input word
  localparam int TD_ROW_LO  = 0;
  localparam int TD_BITS_LO = TD_ROW_LO + NODE_W;
  localparam int TD_SEED_LO = TD_BITS_LO + ROW_W;

  localparam logic CFG_NODE_COUNT   = 1'b0;
  localparam logic CFG_TARGET_COUNT = 1'b1;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;

  typedef enum logic [2:0] {
    STEP_IDLE,
    STEP_CHECK,
    STEP_QWAIT,
    STEP_AWAIT,
    STEP_SCAN,
    STEP_EMIT
  } step_t;

  typedef enum logic [2:0] {
    JC_NEVER,
    JC_ALWAYS,
    JC_RUN_START,
    JC_WALK_DONE,
    JC_ROW_DONE,
    JC_LAST_SENT
  } jcond_t;

  // one microcode word: datapath enables, jump condition and target,
  // and whether to fall through to the next step when no jump is taken
  typedef struct packed {
    logic   take_in;
    logic   deq;
    logic   adj_rd;
    logic   row_ld;
    logic   scan;
    logic   emit;
    jcond_t jcond;
    step_t  target;
    logic   advance;
  } uword_t;

  function automatic uword_t ucode_rom(step_t s);
    uword_t w;
    w = '{take_in: 1'b0, deq: 1'b0, adj_rd: 1'b0, row_ld: 1'b0, scan: 1'b0, emit: 1'b0,
          jcond: JC_ALWAYS, target: STEP_IDLE, advance: 1'b0};
    case (s)
      STEP_IDLE: begin
        w.take_in = 1'b1;
        w.jcond   = JC_RUN_START;
        w.target  = STEP_CHECK;
      end
      STEP_CHECK: begin
        w.deq     = 1'b1;
        w.jcond   = JC_WALK_DONE;
        w.target  = STEP_EMIT;
        w.advance = 1'b1;
      end
      STEP_QWAIT: begin
        w.adj_rd  = 1'b1;
        w.jcond   = JC_NEVER;
        w.advance = 1'b1;
      end
      STEP_AWAIT: begin
        w.row_ld  = 1'b1;
        w.jcond   = JC_NEVER;
        w.advance = 1'b1;
      end
      STEP_SCAN: begin
        w.scan   = 1'b1;
        w.jcond  = JC_ROW_DONE;
        w.target = STEP_CHECK;
      end
      STEP_EMIT: begin
        w.emit   = 1'b1;
        w.jcond  = JC_LAST_SENT;
        w.target = STEP_IDLE;
      end
      default: begin
        w.jcond  = JC_ALWAYS;
        w.target = STEP_IDLE;
      end
    endcase
    return w;
  endfunction

  // index of the single set bit of a one-hot vector
  function automatic logic [NODE_W-1:0] onehot_index(logic [MAX_NODES-1:0] v);
    logic [NODE_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < MAX_NODES; i++) begin
      if (v[i]) idx = idx | NODE_W'(i);
    end
    return idx;
  endfunction

endpackage

[design/bbfs_ram.sv]
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bbfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[design/bounded_bfs_candidate_select_unit.sv]
// Bounded BFS candidate selector: microcoded walk over a bitmap adjacency RAM.
// Depends on bbfs_pkg and bbfs_ram.
// A load word is taken in the idle step and writes one adjacency row. A run word is
// accepted, then each dequeued node goes through a queue RAM read, an adjacency RAM read
// and a row load, then scan steps that add its new neighbors and close the row; a final
// check ends the walk, then one output word per candidate. Reset: synchronous active low,
// clears control, node_count to 64, target_count to 0; RAM contents are not cleared.
module bounded_bfs_candidate_select_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [5:0] row_index, [69:6] row_bits, [75:70] seed_node, [79:76] zero
  input  logic [bbfs_pkg::IN_TDATA_W-1:0]       in_tdata,
  // [0] op
  input  logic                                  in_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [5:0] node_id, [7:6] zero
  output logic [bbfs_pkg::OUT_TDATA_W-1:0]      out_tdata,
  output logic                                  out_tlast,
  input  logic                                  cfg_we,
  input  logic                                  cfg_addr,
  input  logic [bbfs_pkg::CFG_W-1:0]            cfg_wdata
);

  localparam int N  = bbfs_pkg::MAX_NODES;
  localparam int NW = bbfs_pkg::NODE_W;
  localparam int CW = bbfs_pkg::CNT_W;

  bbfs_pkg::step_t  step_r, step_nxt;
  bbfs_pkg::uword_t uw;

  logic [bbfs_pkg::CFG_W-1:0] node_count_r, target_count_r;
  logic [N-1:0]  visited_r;
  logic [N-1:0]  row_r;
  logic [CW-1:0] head_r, tail_r, total_r;
  logic          out_valid_r, out_last_r;
  logic [NW-1:0] out_node_r;

  logic                   in_fire, run_start, load_go;
  logic [NW-1:0]          row_index, seed_node, seed_c;
  logic [bbfs_pkg::ROW_W-1:0] row_bits;
  logic [CW-1:0]          n_eff;
  logic [N-1:0]           node_mask;
  logic [N-1:0]           pending, pend_one, emit_one, emit_rest;
  logic                   pend_hit, row_done, walk_done, out_free, emit_go, emit_last;
  logic [CW:0]            total_inc;
  logic [NW-1:0]          pend_idx;
  logic                   jump;

  logic          q_we, q_re;
  logic [NW-1:0] q_waddr, q_wdata, q_rdata;
  logic          adj_we;
  logic [bbfs_pkg::ROW_W-1:0] adj_rdata;

  assign uw        = bbfs_pkg::ucode_rom(step_r);
  assign in_tready = uw.take_in;
  assign in_fire   = in_tvalid && in_tready;
  assign run_start = in_fire && (in_tuser == bbfs_pkg::OP_RUN);
  assign load_go   = in_fire && (in_tuser == bbfs_pkg::OP_LOAD);

  assign row_index = in_tdata[bbfs_pkg::TD_ROW_LO +: NW];
  assign row_bits  = in_tdata[bbfs_pkg::TD_BITS_LO +: bbfs_pkg::ROW_W];
  assign seed_node = in_tdata[bbfs_pkg::TD_SEED_LO +: NW];

  // node count clamped to 1..N, plus the mask of nodes in use
  always_comb begin
    if (node_count_r == '0) begin
      n_eff = CW'(1);
    end else if (node_count_r > bbfs_pkg::CFG_W'(N)) begin
      n_eff = CW'(N);
    end else begin
      n_eff = CW'(node_count_r);
    end
    for (int i = 0; i < N; i++) begin
      node_mask[i] = (CW'(i) < n_eff);
    end
  end

  always_comb begin
    seed_c = seed_node;
    if ({1'b0, seed_node} >= n_eff) begin
      seed_c = NW'(n_eff - CW'(1));
    end
  end

  // neighbor scan: lowest unvisited neighbor each cycle keeps ascending order
  assign pending   = row_r & ~visited_r;
  assign pend_hit  = |pending;
  assign pend_one  = pending & (~pending + N'(1));
  assign pend_idx  = bbfs_pkg::onehot_index(pend_one);
  assign total_inc = {1'b0, total_r} + (CW+1)'(1);
  assign row_done  = !pend_hit || (total_inc >= (CW+1)'(target_count_r));
  assign walk_done = (head_r == tail_r) || (total_r >= CW'(target_count_r));

  // emission drains the visited map lowest bit first
  assign emit_one  = visited_r & (~visited_r + N'(1));
  assign emit_rest = visited_r & ~emit_one;
  assign emit_last = (emit_rest == '0);
  assign out_free  = !out_valid_r || out_tready;
  assign emit_go   = uw.emit && out_free;

  always_comb begin
    case (uw.jcond)
      bbfs_pkg::JC_NEVER:     jump = 1'b0;
      bbfs_pkg::JC_ALWAYS:    jump = 1'b1;
      bbfs_pkg::JC_RUN_START: jump = run_start;
      bbfs_pkg::JC_WALK_DONE: jump = walk_done;
      bbfs_pkg::JC_ROW_DONE:  jump = row_done;
      bbfs_pkg::JC_LAST_SENT: jump = emit_go && emit_last;
      default:                jump = 1'b0;
    endcase
    if (jump) begin
      step_nxt = uw.target;
    end else if (uw.advance) begin
      step_nxt = bbfs_pkg::step_t'(step_r + 3'd1);
    end else begin
      step_nxt = step_r;
    end
  end

  // walk queue: seed written on run start, neighbors at tail during scan
  assign q_we    = run_start || (uw.scan && pend_hit && (tail_r < CW'(N)));
  assign q_waddr = run_start ? '0 : tail_r[NW-1:0];
  assign q_wdata = run_start ? seed_c : pend_idx;
  assign q_re    = uw.deq && !walk_done;

  bbfs_ram #(.WIDTH(NW), .DEPTH(N)) u_queue (
    .clk     (clk),
    .wr_en   (q_we),
    .wr_addr (q_waddr),
    .wr_data (q_wdata),
    .rd_en   (q_re),
    .rd_addr (head_r[NW-1:0]),
    .rd_data (q_rdata)
  );

  assign adj_we = load_go && ({1'b0, row_index} < CW'(N));

  bbfs_ram #(.WIDTH(bbfs_pkg::ROW_W), .DEPTH(N)) u_adj (
    .clk     (clk),
    .wr_en   (adj_we),
    .wr_addr (row_index),
    .wr_data (row_bits),
    .rd_en   (uw.adj_rd),
    .rd_addr (q_rdata),
    .rd_data (adj_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r         <= bbfs_pkg::STEP_IDLE;
      node_count_r   <= bbfs_pkg::CFG_W'(N);
      target_count_r <= '0;
      visited_r      <= '0;
      head_r         <= '0;
      tail_r         <= '0;
      total_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      step_r <= step_nxt;
      if (cfg_we) begin
        case (cfg_addr)
          bbfs_pkg::CFG_NODE_COUNT:   node_count_r   <= cfg_wdata;
          bbfs_pkg::CFG_TARGET_COUNT: target_count_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (run_start) begin
        visited_r <= N'(1) << seed_c;
        head_r    <= '0;
        tail_r    <= CW'(1);
        total_r   <= CW'(1);
      end
      if (q_re) begin
        head_r <= head_r + CW'(1);
      end
      if (uw.row_ld) begin
        row_r <= adj_rdata[N-1:0] & node_mask;
      end
      if (uw.scan && pend_hit) begin
        visited_r <= visited_r | pend_one;
        total_r   <= total_inc[CW-1:0];
        if (tail_r < CW'(N)) begin
          tail_r <= tail_r + CW'(1);
        end
      end
      if (emit_go) begin
        visited_r   <= emit_rest;
        out_valid_r <= 1'b1;
        out_node_r  <= bbfs_pkg::onehot_index(emit_one);
        out_last_r  <= emit_last;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = bbfs_pkg::OUT_TDATA_W'(out_node_r);
  assign out_tlast  = out_last_r;

  // every visited node during the walk has been counted exactly once
  a_walk_count: assert property (@(posedge clk) disable iff (!rst_n)
    (step_r == bbfs_pkg::STEP_CHECK || step_r == bbfs_pkg::STEP_QWAIT ||
     step_r == bbfs_pkg::STEP_AWAIT || step_r == bbfs_pkg::STEP_SCAN)
    |-> (CW'($countones(visited_r)) == total_r))
    else $error("visited map and candidate total disagree");

  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue head passed tail");

  a_emit_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    step_r == bbfs_pkg::STEP_EMIT |-> visited_r != '0)
    else $error("emitting from an empty candidate map");

endmodule
